[rtl/core/cesd_pkg.sv]
// ----------------------------------------------------------------------------
// cesd_pkg
// Types, character codes and helpers shared by the escape sequence decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cesd_pkg;

  localparam int unsigned MaxOut = 4;
  localparam int unsigned CntW   = $clog2(MaxOut + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,  // nothing pending
    PH_BSL  = 2'd1,  // backslash seen
    PH_X    = 2'd2,  // backslash x seen
    PH_XH   = 2'd3   // backslash x and one hex digit seen
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] first_hex;
  } cesd_state_t;

  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;  // entry 0 goes out first
    logic [CntW-1:0]        count;
  } cesd_list_t;

  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lower_hex(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h66);
  endfunction

  function automatic logic is_upper_hex(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h46);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || is_lower_hex(c) || is_upper_hex(c);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (is_digit(c)) begin
      v = c - 8'h30;
    end else if (is_lower_hex(c)) begin
      v = c - 8'h57;
    end else if (is_upper_hex(c)) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/cesd_step.sv]
// ----------------------------------------------------------------------------
// cesd_step
// Decode step for one byte: builds the list of output bytes and next state.
// ----------------------------------------------------------------------------
`default_nettype none

module cesd_step
  import cesd_pkg::*;
(
  input  cesd_state_t cur,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output cesd_list_t  list,
  output cesd_state_t nxt
);

  always_comb begin
    logic [CntW-1:0] n;
    logic            handled;
    phase_t          ph;
    logic [7:0]      fh;

    list    = '0;
    n       = '0;
    handled = 1'b0;
    ph      = cur.phase;
    fh      = cur.first_hex;

    unique case (cur.phase)
      PH_BSL: begin
        handled = 1'b1;
        ph      = PH_IDLE;
        unique case (in_byte)
          CH_QUOTE, CH_BSL: begin
            list.bytes[n[1:0]] = in_byte;
            n = n + 1'b1;
          end
          CH_N: begin
            list.bytes[n[1:0]] = CH_LF;
            n = n + 1'b1;
          end
          CH_R: begin
            list.bytes[n[1:0]] = CH_CR;
            n = n + 1'b1;
          end
          CH_T: begin
            list.bytes[n[1:0]] = CH_TAB;
            n = n + 1'b1;
          end
          CH_X: begin
            ph = PH_X;
          end
          default: begin
            handled = 1'b0;
            ph      = cur.phase;
          end
        endcase
      end
      PH_X: begin
        if (is_hex(in_byte)) begin
          handled = 1'b1;
          fh      = in_byte;
          ph      = PH_XH;
        end
      end
      PH_XH: begin
        if (is_hex(in_byte)) begin
          handled = 1'b1;
          list.bytes[n[1:0]] = {hex_nibble(cur.first_hex), hex_nibble(in_byte)};
          n  = n + 1'b1;
          ph = PH_IDLE;
          fh = 8'h00;
        end
      end
      default: begin
      end
    endcase

    // broken sequence: send what was held, then treat the byte as fresh
    if (!handled) begin
      if (cur.phase != PH_IDLE) begin
        list.bytes[n[1:0]] = CH_BSL;
        n = n + 1'b1;
      end
      if (cur.phase == PH_X || cur.phase == PH_XH) begin
        list.bytes[n[1:0]] = CH_X;
        n = n + 1'b1;
      end
      if (cur.phase == PH_XH) begin
        list.bytes[n[1:0]] = cur.first_hex;
        n = n + 1'b1;
      end
      fh = 8'h00;
      if (in_byte == CH_BSL) begin
        ph = PH_BSL;
      end else begin
        ph = PH_IDLE;
        list.bytes[n[1:0]] = in_byte;
        n = n + 1'b1;
      end
    end

    // end of text: flush whatever is still pending
    if (in_last) begin
      if (ph != PH_IDLE) begin
        list.bytes[n[1:0]] = CH_BSL;
        n = n + 1'b1;
      end
      if (ph == PH_X || ph == PH_XH) begin
        list.bytes[n[1:0]] = CH_X;
        n = n + 1'b1;
      end
      if (ph == PH_XH) begin
        list.bytes[n[1:0]] = fh;
        n = n + 1'b1;
      end
      ph = PH_IDLE;
      fh = 8'h00;
    end

    list.count    = n;
    nxt.phase     = ph;
    nxt.first_hex = fh;
  end

endmodule

`default_nettype wire

[rtl/core/c_escape_sequence_decoder.sv]
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder
// Byte-stream decoder for C string backslash escapes.
// ----------------------------------------------------------------------------
// Takes one byte per transfer and decodes \" \\ \n \r \t and \xHH; broken
// sequences are passed on as received, and in_last flushes any pending
// sequence. Each input byte is decoded in the cycle it is accepted and its
// results (zero to four bytes) are loaded into an output list that drains
// one byte per cycle while out_stall is low. A new input byte is accepted
// while the list is empty or its last entry is leaving; a byte that yields
// several results holds the input until they have drained.
// run_last marks the last byte produced by an input byte, text_end the last
// byte of the text.
`default_nettype none

module c_escape_sequence_decoder
  import cesd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       text_end
);

  cesd_state_t state;
  cesd_state_t state_next;
  cesd_list_t  step_list;

  logic [MaxOut-1:0][7:0] bytes;
  logic [CntW-1:0]        count;
  logic                   last;
  logic                   load;
  logic                   drain;

  cesd_step u_step (
    .cur     (state),
    .in_byte (in_byte),
    .in_last (in_last),
    .list    (step_list),
    .nxt     (state_next)
  );

  assign out_valid = (count != '0);
  assign drain     = out_valid && !out_stall;
  // accept while the list is empty or its final entry leaves this cycle
  assign in_stall  = (count > CntW'(1)) || ((count == CntW'(1)) && out_stall);
  assign load      = in_valid && !in_stall;

  assign out_byte  = bytes[0];
  assign run_last  = (count == CntW'(1));
  assign text_end  = run_last && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase     <= PH_IDLE;
      state.first_hex <= 8'h00;
      count           <= '0;
    end else if (load) begin
      state <= state_next;
      count <= step_list.count;
    end else if (drain) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= step_list.bytes;
      last  <= in_last;
    end else if (drain) begin
      bytes <= {8'h00, bytes[MaxOut-1:1]};
    end
  end

endmodule

`default_nettype wire

[verif/tb_c_escape_sequence_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_c_escape_sequence_decoder
// Self-checking bench for the C escape sequence decoder.
// ----------------------------------------------------------------------------
// A queue of text bytes (directed escapes, broken and truncated sequences,
// then random text) feeds a clocked driver. Every input transfer runs through
// a local decoder model that queues the bytes the block must send. A clocked
// monitor checks each output transfer against the oldest queued byte. Both
// sides idle in random bursts, and the receiver holds off once for a long
// stretch so that the block backs up into its input.
module tb_c_escape_sequence_decoder;
  import cesd_pkg::*;

  localparam int ResetCycles   = 6;
  localparam int StallLimit    = 2000;
  localparam int DrainCycles   = 16;
  localparam int RandomItems   = 90;
  localparam int QuietTail     = 25;
  localparam int HoldOffAt     = 40;
  localparam int HoldOffCycles = 150;

  localparam logic [7:0] ASC_0    = 8'h30;
  localparam logic [7:0] ASC_7    = 8'h37;
  localparam logic [7:0] ASC_9    = 8'h39;
  localparam logic [7:0] ASC_A_UP = 8'h41;
  localparam logic [7:0] ASC_F_UP = 8'h46;
  localparam logic [7:0] ASC_A_LO = 8'h61;
  localparam logic [7:0] ASC_F_LO = 8'h66;
  localparam logic [7:0] ASC_G_LO = 8'h67;
  localparam logic [7:0] ASC_Q_LO = 8'h71;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } text_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       run_end;
    logic       text_done;
  } dec_byte_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_end;

  text_item_t text_q[$];
  logic [7:0] seq_buf[$];
  dec_byte_t  decoded_q[$];
  logic [7:0] run_bytes[$];

  // decoder model state
  phase_t     dec_phase = PH_IDLE;
  logic [7:0] held_hex  = 8'h00;

  text_item_t drv_item;
  dec_byte_t  mon_want;
  int         total_items  = 0;
  int         sent_cnt     = 0;
  int         stuck_cycles = 0;
  int         fail_cnt     = 0;
  int         send_gap     = 0;
  int         hold_left    = 0;
  bit         send_calm    = 1'b0;
  bit         recv_calm    = 1'b0;
  bit         held_off     = 1'b0;

  c_escape_sequence_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_end  (text_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic is_hex_char(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    return (c >= ASC_0 && c <= ASC_9) || (lc >= ASC_A_LO && lc <= ASC_F_LO);
  endfunction

  // letters sit at 1..6 in the low nibble for both cases
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c <= ASC_9) begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) begin
      return ASC_0 + 8'(v);
    end else if ($urandom_range(0, 1) == 1) begin
      return ASC_A_LO + 8'(v - 10);
    end
    return ASC_A_UP + 8'(v - 10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) begin
      return CH_BSL;
    end
    do begin
      c = 8'($urandom_range(0, 255));
    end while (is_hex_char(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_BSL);
    return c;
  endfunction

  function automatic logic [7:0] rand_bad_escape();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_QUOTE || c == CH_BSL || c == CH_N || c == CH_R ||
               c == CH_T || c == CH_X);
    return c;
  endfunction

  task add_seq(input logic last);
    text_item_t it;
    foreach (seq_buf[k]) begin
      it.b    = seq_buf[k];
      it.last = last && (k == seq_buf.size() - 1);
      text_q.push_back(it);
    end
    seq_buf.delete();
  endtask

  // send whatever part of an escape is pending, as received
  task flush_held();
    if (dec_phase != PH_IDLE) begin
      run_bytes.push_back(CH_BSL);
    end
    if (dec_phase == PH_X || dec_phase == PH_XH) begin
      run_bytes.push_back(CH_X);
    end
    if (dec_phase == PH_XH) begin
      run_bytes.push_back(held_hex);
    end
    dec_phase = PH_IDLE;
    held_hex  = 8'h00;
  endtask

  task predict_decode(input logic [7:0] b, input logic last);
    logic      taken;
    dec_byte_t r;
    taken = 1'b0;
    run_bytes.delete();
    case (dec_phase)
      PH_BSL: begin
        taken = 1'b1;
        case (b)
          CH_QUOTE, CH_BSL: begin
            run_bytes.push_back(b);
            dec_phase = PH_IDLE;
          end
          CH_N: begin
            run_bytes.push_back(CH_LF);
            dec_phase = PH_IDLE;
          end
          CH_R: begin
            run_bytes.push_back(CH_CR);
            dec_phase = PH_IDLE;
          end
          CH_T: begin
            run_bytes.push_back(CH_TAB);
            dec_phase = PH_IDLE;
          end
          CH_X: dec_phase = PH_X;
          default: begin
            flush_held();
            taken = 1'b0;
          end
        endcase
      end
      PH_X: begin
        if (is_hex_char(b)) begin
          held_hex  = b;
          dec_phase = PH_XH;
          taken     = 1'b1;
        end else begin
          flush_held();
        end
      end
      PH_XH: begin
        if (is_hex_char(b)) begin
          run_bytes.push_back({nibble_of(held_hex), nibble_of(b)});
          dec_phase = PH_IDLE;
          held_hex  = 8'h00;
          taken     = 1'b1;
        end else begin
          flush_held();
        end
      end
      default: ;
    endcase
    // idle, or the breaking byte of a sequence just flushed
    if (!taken) begin
      if (b == CH_BSL) begin
        dec_phase = PH_BSL;
      end else begin
        run_bytes.push_back(b);
      end
    end
    if (last) begin
      flush_held();
    end
    foreach (run_bytes[k]) begin
      r.b         = run_bytes[k];
      r.run_end   = (k == run_bytes.size() - 1);
      r.text_done = r.run_end && last;
      decoded_q.push_back(r);
    end
  endtask

  // driver: payload only moves when the slot is empty or just transferred
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_decode(in_byte, in_last);
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid || !in_stall) begin
        if ($urandom_range(0, 29) == 0) begin
          send_calm = !send_calm;
        end
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (text_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!send_calm && text_q.size() > QuietTail &&
                     $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else begin
          drv_item = text_q.pop_front();
          in_valid <= 1'b1;
          in_byte  <= drv_item.b;
          in_last  <= drv_item.last;
        end
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 29) == 0) begin
        recv_calm = !recv_calm;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held_off && sent_cnt >= HoldOffAt) begin
        held_off  = 1'b1;
        hold_left = HoldOffCycles - 1;
        out_stall <= 1'b1;
      end else if (!recv_calm && sent_cnt < total_items - QuietTail &&
                   $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("out_byte %02h with nothing expected", out_byte);
        fail_cnt++;
      end else begin
        mon_want = decoded_q.pop_front();
        if (out_byte !== mon_want.b) begin
          $error("out_byte: expected %02h, actual %02h", mon_want.b, out_byte);
          fail_cnt++;
        end
        if (run_last !== mon_want.run_end) begin
          $error("run_last: expected %0b, actual %0b", mon_want.run_end, run_last);
          fail_cnt++;
        end
        if (text_end !== mon_want.text_done) begin
          $error("text_end: expected %0b, actual %0b", mon_want.text_done, text_end);
          fail_cnt++;
        end
      end
    end
  end

  // cycles without any transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int gen_cnt;
    int pick;
    int n;
    bit cut;
    gen_cnt = 0;

    // extreme bytes, every escape, mixed-case hex, broken and truncated escapes
    seq_buf = '{8'h00, 8'hFF, CH_BSL, CH_QUOTE, CH_BSL, CH_BSL, CH_BSL, CH_N,
                CH_BSL, CH_R, CH_BSL, CH_T, CH_BSL, CH_X, ASC_A_LO, ASC_F_UP,
                CH_BSL, ASC_Q_LO, CH_BSL, CH_X, ASC_G_LO,
                CH_BSL, CH_X, ASC_A_UP, CH_BSL, CH_X, ASC_7};
    add_seq(1'b1);
    seq_buf = '{CH_BSL};
    add_seq(1'b1);
    seq_buf = '{CH_BSL, CH_X};
    add_seq(1'b1);

    while (gen_cnt < RandomItems) begin
      pick = $urandom_range(0, 99);
      cut  = 1'b0;
      if (pick < 30) begin
        n = $urandom_range(1, 3);
        repeat (n) seq_buf.push_back(rand_plain());
      end else if (pick < 60) begin
        seq_buf.push_back(CH_BSL);
        case ($urandom_range(0, 4))
          0: seq_buf.push_back(CH_QUOTE);
          1: seq_buf.push_back(CH_BSL);
          2: seq_buf.push_back(CH_N);
          3: seq_buf.push_back(CH_R);
          default: seq_buf.push_back(CH_T);
        endcase
      end else if (pick < 75) begin
        seq_buf = '{CH_BSL, CH_X, rand_hex_digit(), rand_hex_digit()};
      end else if (pick < 85) begin
        case ($urandom_range(0, 2))
          0: seq_buf = '{CH_BSL, rand_bad_escape()};
          1: seq_buf = '{CH_BSL, CH_X, rand_non_hex()};
          default: seq_buf = '{CH_BSL, CH_X, rand_hex_digit(), rand_non_hex()};
        endcase
      end else if (pick < 93) begin
        n = $urandom_range(1, 4);
        repeat (n) seq_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        // text ends inside an escape
        seq_buf = '{CH_BSL, CH_X, rand_hex_digit()};
        n = $urandom_range(0, 2);
        repeat (n) void'(seq_buf.pop_back());
        cut = 1'b1;
      end
      gen_cnt += seq_buf.size();
      add_seq(cut || $urandom_range(0, 9) == 0);
    end
    seq_buf = '{rand_plain()};
    add_seq(1'b1);
    total_items = text_q.size();

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    while ((sent_cnt < total_items || decoded_q.size() != 0) &&
           stuck_cycles < StallLimit) begin
      @(negedge clk);
    end
    if (stuck_cycles < StallLimit) begin
      repeat (DrainCycles) @(negedge clk);
    end
    if (fail_cnt == 0 && stuck_cycles < StallLimit && decoded_q.size() == 0) begin
      $display("[c_escape_sequence_decoder] OK");
    end else begin
      $display("[c_escape_sequence_decoder] ERROR");
    end
    $finish;
  end

endmodule
